// File: src/aoad_pkg.sv
package aoad_pkg;

   localparam int NUM_AXES          = 3;
   localparam int SMP_W             = 16;
   localparam int DATA_W            = NUM_AXES * SMP_W;
   localparam int SUM_W             = 32;
   localparam int QUO_W             = 16;
   localparam int LEN_W             = 11;
   localparam int WIN_W             = 15;
   localparam int CSR_IDX_W         = 3;
   localparam int CSR_DATA_W        = 15;
   localparam int CAL_WORDS_DEF     = 800;

   localparam logic [LEN_W-1:0] AVG_SAMPLES_RST = LEN_W'(40);
   localparam logic [1:0]       ZPC_STATIONARY  = 2'd2;

   typedef logic signed [SMP_W-1:0] smp_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AVG_SAMPLES = 3'd0,
      CSR_WINDOW_X    = 3'd1,
      CSR_WINDOW_Y    = 3'd2,
      CSR_WINDOW_Z    = 3'd3,
      CSR_RECALIB_EN  = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_PDIV,
      ST_EMIT,
      ST_RDEC,
      ST_RDIV
   } state_type;

   // control from the sequencer to the bit-serial accumulator
   typedef struct packed {
      logic start;
      logic per_en;
      logic rec_en;
      logic clr_per;
      logic clr_rec;
   } acc_ctrl_type;

endpackage

// File: src/accel_offset_average_deadband_core.sv
// Accelerometer offset removal, period averaging and deadband. Each input word is one
// signed x/y/z sample. The first CAL_WORDS words after reset only set the per-axis
// offsets (mean, truncated toward zero) and give no output. After that every word adds
// sample minus offset into per-axis period sums, and at the end of each averaging period
// one output word carries the truncated means, zeroed below each axis window and saturated
// to 16 bits, with tuser set once two periods in a row came out all zero. While that
// flag is set and recalib_enable is 1, raw samples are averaged over CAL_WORDS words
// and each offset moves halfway toward that mean. Sums are added one bit per cycle
// through 32-bit shift registers and divided by one shared radix-2 divider, one
// quotient bit per cycle. A word that closes a period also runs three divisions and
// the output load, and one more accumulation pass when it is also summed for
// recalibration; a word that closes a calibration run also runs the three offset
// divisions. The output register lets the next word in while a result waits; only a
// new result stalls on a full output register.
module accel_offset_average_deadband_core import aoad_pkg::*; #(
   parameter int CAL_WORDS = CAL_WORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: sample_x, sample_y, sample_z
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,
   // rsp_tdata: avg_x, avg_y, avg_z
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: stationary
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int RC_W  = $clog2(CAL_WORDS + 1);
   localparam int DIV_W = (RC_W > LEN_W) ? RC_W : LEN_W;

   localparam logic [QUO_W-1:0] POS_LIM = QUO_W'(16'h7FFF);
   localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(16'h8000);
   localparam smp_type SMP_MAX = 16'sh7FFF;
   localparam smp_type SMP_MIN = 16'sh8000;

   function automatic smp_type sat_avg(input logic o, input logic n,
                                       input logic [QUO_W-1:0] q);
      smp_type res;
      if (o) begin
         res = n ? SMP_MIN : SMP_MAX;
      end else if (n) begin
         res = (q > NEG_LIM) ? SMP_MIN : smp_type'(~q + 1'b1);
      end else begin
         res = (q > POS_LIM) ? SMP_MAX : smp_type'(q);
      end
      return res;
   endfunction

   // configuration
   logic [LEN_W-1:0] avg_samples_ff, avg_samples_in;
   logic [WIN_W-1:0] win_ff [NUM_AXES];
   logic [WIN_W-1:0] win_in [NUM_AXES];
   logic             recal_en_ff, recal_en_in;

   // control
   state_type        state_ff, state_in;
   logic [1:0]       axis_ff, axis_in;
   logic             div_run_ff, div_run_in;
   logic             init_cal_ff, init_cal_in;
   logic             init_item_ff, init_item_in;
   logic             per_end_ff, per_end_in;
   logic             rec_done_ff, rec_done_in;
   logic [LEN_W-1:0] pcount_ff, pcount_in;
   logic [RC_W-1:0]  rcount_ff, rcount_in;
   logic [1:0]       zpc_ff, zpc_in;
   logic             allz_ff, allz_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   smp_type          offset_ff [NUM_AXES];
   smp_type          offset_in [NUM_AXES];

   // payload
   smp_type          smp_ff [NUM_AXES];
   smp_type          smp_in [NUM_AXES];
   smp_type          avg_ff [NUM_AXES];
   smp_type          avg_in [NUM_AXES];
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_stat_ff, rsp_stat_in;

   // datapath links
   acc_ctrl_type     acc_ctrl;
   smp_type          acc_sample [NUM_AXES];
   logic             acc_done;
   sum_type          psum [NUM_AXES];
   sum_type          rsum [NUM_AXES];
   logic             div_start;
   sum_type          div_dividend;
   logic [DIV_W-1:0] div_divisor;
   logic             div_done;
   logic [QUO_W-1:0] div_quo;
   logic             div_neg;
   logic             div_ovf;

   logic             accept;
   logic             rsp_free;
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] pcount_nx;
   logic [RC_W-1:0]  rcount_nx;
   logic [1:0]       zpc_nx;
   logic             per_end_now;
   logic             rec_now;
   logic             keep;
   smp_type          avg_val;
   logic signed [QUO_W:0]   r_val;
   logic signed [SMP_W+1:0] ofs_sum;
   logic signed [SMP_W+1:0] ofs_adj;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;

   assign len         = (avg_samples_ff == '0) ? LEN_W'(1) : avg_samples_ff;
   assign pcount_nx   = pcount_ff + 1'b1;
   assign rcount_nx   = rcount_ff + 1'b1;
   assign per_end_now = !init_cal_ff && (pcount_nx == len);
   assign rec_now     = init_cal_ff ||
                        (!per_end_now && recal_en_ff && (zpc_ff >= ZPC_STATIONARY));

   always_comb begin
      for (int j = 0; j < NUM_AXES; j++) begin
         smp_in[j]     = accept ? req_tdata[j*SMP_W +: SMP_W] : smp_ff[j];
         // the first pass loads straight from the port, a later pass from the held word
         acc_sample[j] = (state_ff == ST_IDLE) ? req_tdata[j*SMP_W +: SMP_W] : smp_ff[j];
      end
   end

   aoad_serial_acc u_acc (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (acc_ctrl),
      .sample (acc_sample),
      .offset (offset_ff),
      .done   (acc_done),
      .psum   (psum),
      .rsum   (rsum)
   );

   assign div_start    = ((state_ff == ST_PDIV) || (state_ff == ST_RDIV)) && !div_run_ff;
   assign div_dividend = (state_ff == ST_PDIV) ? psum[axis_ff] : rsum[axis_ff];
   assign div_divisor  = (state_ff == ST_PDIV) ? DIV_W'(len) : DIV_W'(CAL_WORDS);

   aoad_divider #(
      .DIV_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quo      (div_quo),
      .neg      (div_neg),
      .ovf      (div_ovf)
   );

   always_comb begin
      keep    = div_ovf || (div_quo >= QUO_W'(win_ff[axis_ff]));
      avg_val = keep ? sat_avg(div_ovf, div_neg, div_quo) : '0;
      r_val   = div_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
      ofs_sum = (SMP_W+2)'(offset_ff[axis_ff]) + (SMP_W+2)'(r_val);
      // halve toward zero
      ofs_adj = ofs_sum + (SMP_W+2)'(ofs_sum[SMP_W+1]);
      if (!allz_ff) begin
         zpc_nx = '0;
      end else if (zpc_ff < ZPC_STATIONARY) begin
         zpc_nx = zpc_ff + 1'b1;
      end else begin
         zpc_nx = zpc_ff;
      end
   end

   // configuration writes
   always_comb begin
      avg_samples_in = avg_samples_ff;
      win_in         = win_ff;
      recal_en_in    = recal_en_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_AVG_SAMPLES: avg_samples_in = csr_wdata[LEN_W-1:0];
            CSR_WINDOW_X:    win_in[0]      = csr_wdata[WIN_W-1:0];
            CSR_WINDOW_Y:    win_in[1]      = csr_wdata[WIN_W-1:0];
            CSR_WINDOW_Z:    win_in[2]      = csr_wdata[WIN_W-1:0];
            CSR_RECALIB_EN:  recal_en_in    = csr_wdata[0];
            default:         ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      init_cal_in   = init_cal_ff;
      init_item_in  = init_item_ff;
      per_end_in    = per_end_ff;
      rec_done_in   = rec_done_ff;
      pcount_in     = pcount_ff;
      rcount_in     = rcount_ff;
      zpc_in        = zpc_ff;
      allz_in       = allz_ff;
      offset_in     = offset_ff;
      avg_in        = avg_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_stat_in   = rsp_stat_ff;
      acc_ctrl      = '0;
      div_run_in    = div_start ? 1'b1 : (div_done ? 1'b0 : div_run_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               acc_ctrl.start  = 1'b1;
               acc_ctrl.per_en = !init_cal_ff;
               acc_ctrl.rec_en = rec_now;
               init_item_in    = init_cal_ff;
               per_end_in      = per_end_now;
               rec_done_in     = rec_now;
               if (!init_cal_ff) begin
                  pcount_in = per_end_now ? '0 : pcount_nx;
               end
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (acc_done) begin
               axis_in  = '0;
               allz_in  = 1'b1;
               state_in = per_end_ff ? ST_PDIV : ST_RDEC;
            end
         end
         ST_PDIV: begin
            if (div_done) begin
               avg_in[axis_ff] = avg_val;
               if (keep) begin
                  allz_in = 1'b0;
               end
               if (axis_ff == 2'(NUM_AXES - 1)) begin
                  state_in = ST_EMIT;
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_tvalid_in    = 1'b1;
               rsp_data_in      = {avg_ff[2], avg_ff[1], avg_ff[0]};
               rsp_stat_in      = zpc_nx >= ZPC_STATIONARY;
               zpc_in           = zpc_nx;
               acc_ctrl.clr_per = 1'b1;
               per_end_in       = 1'b0;
               state_in         = ST_RDEC;
            end
         end
         ST_RDEC: begin
            if (rec_done_ff) begin
               rcount_in = rcount_nx;
               if (rcount_nx == RC_W'(CAL_WORDS)) begin
                  axis_in  = '0;
                  state_in = ST_RDIV;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (recal_en_ff && (zpc_ff >= ZPC_STATIONARY)) begin
               // period just closed into the stationary state: sum this word too
               acc_ctrl.start  = 1'b1;
               acc_ctrl.rec_en = 1'b1;
               rec_done_in     = 1'b1;
               state_in        = ST_ACC;
            end else begin
               if (recal_en_ff) begin
                  acc_ctrl.clr_rec = 1'b1;
                  rcount_in        = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_RDIV: begin
            if (div_done) begin
               offset_in[axis_ff] = init_item_ff ? smp_type'(r_val[SMP_W-1:0])
                                                 : smp_type'(ofs_adj[SMP_W:1]);
               if (axis_ff == 2'(NUM_AXES - 1)) begin
                  acc_ctrl.clr_rec = 1'b1;
                  rcount_in        = '0;
                  init_cal_in      = 1'b0;
                  state_in         = ST_IDLE;
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         axis_ff        <= '0;
         div_run_ff     <= 1'b0;
         init_cal_ff    <= 1'b1;
         init_item_ff   <= 1'b0;
         per_end_ff     <= 1'b0;
         rec_done_ff    <= 1'b0;
         pcount_ff      <= '0;
         rcount_ff      <= '0;
         zpc_ff         <= '0;
         allz_ff        <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
         avg_samples_ff <= AVG_SAMPLES_RST;
         recal_en_ff    <= 1'b1;
         for (int j = 0; j < NUM_AXES; j++) begin
            offset_ff[j] <= '0;
            win_ff[j]    <= '0;
         end
      end else begin
         state_ff       <= state_in;
         axis_ff        <= axis_in;
         div_run_ff     <= div_run_in;
         init_cal_ff    <= init_cal_in;
         init_item_ff   <= init_item_in;
         per_end_ff     <= per_end_in;
         rec_done_ff    <= rec_done_in;
         pcount_ff      <= pcount_in;
         rcount_ff      <= rcount_in;
         zpc_ff         <= zpc_in;
         allz_ff        <= allz_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
         avg_samples_ff <= avg_samples_in;
         recal_en_ff    <= recal_en_in;
         offset_ff      <= offset_in;
         win_ff         <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff      <= smp_in;
      avg_ff      <= avg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   // the shared divider only runs inside the two division phases
   a_div_phase: assert property (@(posedge clock) disable iff (reset)
      div_run_ff |-> ((state_ff == ST_PDIV) || (state_ff == ST_RDIV)))
      else $error("divider running outside a division phase");

   // the calibration count closes exactly at CAL_WORDS
   a_rcount_range: assert property (@(posedge clock) disable iff (reset)
      rcount_ff <= RC_W'(CAL_WORDS))
      else $error("recalibration count past its limit");

   // no result is produced for a word of the initial calibration
   a_no_emit_calib: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (!init_item_ff && !init_cal_ff))
      else $error("result during initial calibration");

   // a fresh result is only loaded when the output register frees up
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready) |=> (rsp_tvalid_ff && $stable(rsp_data_ff)))
      else $error("pending output word overwritten");

endmodule

// File: src/aoad_serial_acc.sv
module aoad_serial_acc import aoad_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  acc_ctrl_type ctrl,
   input  smp_type      sample [NUM_AXES],
   input  smp_type      offset [NUM_AXES],
   output logic         done,
   output sum_type      psum [NUM_AXES],
   output sum_type      rsum [NUM_AXES]
);

   localparam int CNT_W = $clog2(SUM_W);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             per_en_ff, per_en_in;
   logic             rec_en_ff, rec_en_in;

   assign done = busy_ff && (cnt_ff == CNT_W'(SUM_W - 1));

   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      per_en_in = per_en_ff;
      rec_en_in = rec_en_ff;
      if (ctrl.start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         per_en_in = ctrl.per_en;
         rec_en_in = ctrl.rec_en;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         cnt_ff    <= '0;
         per_en_ff <= 1'b0;
         rec_en_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         cnt_ff    <= cnt_in;
         per_en_ff <= per_en_in;
         rec_en_ff <= rec_en_in;
      end
   end

   // one lane per axis; sums rotate LSB first and are back in place after a full pass
   for (genvar j = 0; j < NUM_AXES; j++) begin : g_lane
      smp_type    smp_ff, smp_in;
      smp_type    ofs_ff, ofs_in;
      logic [1:0] pc_ff, pc_in;
      logic       rc_ff, rc_in;
      sum_type    psum_ff, psum_in;
      sum_type    rsum_ff, rsum_in;
      logic [2:0] ptot;
      logic [1:0] rtot;

      always_comb begin
         // period: sum + sample + ~offset + 1 (carry preset to one)
         ptot    = 3'(psum_ff[0]) + 3'(smp_ff[0]) + 3'(ofs_ff[0]) + 3'(pc_ff);
         rtot    = 2'(rsum_ff[0]) + 2'(smp_ff[0]) + 2'(rc_ff);
         smp_in  = smp_ff;
         ofs_in  = ofs_ff;
         pc_in   = pc_ff;
         rc_in   = rc_ff;
         psum_in = psum_ff;
         rsum_in = rsum_ff;
         if (ctrl.start) begin
            smp_in = sample[j];
            ofs_in = ~offset[j];
            pc_in  = 2'd1;
            rc_in  = 1'b0;
         end else if (busy_ff) begin
            smp_in  = {smp_ff[SMP_W-1], smp_ff[SMP_W-1:1]};
            ofs_in  = {ofs_ff[SMP_W-1], ofs_ff[SMP_W-1:1]};
            pc_in   = ptot[2:1];
            rc_in   = rtot[1];
            psum_in = {(per_en_ff ? ptot[0] : psum_ff[0]), psum_ff[SUM_W-1:1]};
            rsum_in = {(rec_en_ff ? rtot[0] : rsum_ff[0]), rsum_ff[SUM_W-1:1]};
         end
         if (ctrl.clr_per) begin
            psum_in = '0;
         end
         if (ctrl.clr_rec) begin
            rsum_in = '0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            psum_ff <= '0;
            rsum_ff <= '0;
         end else begin
            psum_ff <= psum_in;
            rsum_ff <= rsum_in;
         end
      end

      always_ff @(posedge clock) begin
         smp_ff <= smp_in;
         ofs_ff <= ofs_in;
         pc_ff  <= pc_in;
         rc_ff  <= rc_in;
      end

      assign psum[j] = psum_ff;
      assign rsum[j] = rsum_ff;
   end

endmodule

// File: src/aoad_divider.sv
module aoad_divider import aoad_pkg::*; #(
   parameter int DIV_W = LEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  sum_type          dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [QUO_W-1:0] quo,
   output logic             neg,
   output logic             ovf
);

   localparam int CNT_W = $clog2(QUO_W);
   localparam int CMP_W = (DIV_W > QUO_W) ? DIV_W : QUO_W;

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic             neg_ff, neg_in;
   logic             ovf_ff, ovf_in;

   logic [SUM_W-1:0] mag;
   logic [CMP_W-1:0] hi_ext;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;
   logic             fits;
   logic             last;

   always_comb begin
      mag    = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      hi_ext = CMP_W'(mag[SUM_W-1:QUO_W]);
      trial  = {rem_ff, quo_ff[QUO_W-1]};
      diff   = trial - {1'b0, divisor};
      fits   = trial >= {1'b0, divisor};
      last   = cnt_ff == CNT_W'(QUO_W - 1);

      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         // quotient only fits QUO_W bits when the high part is below the divisor
         run_in = 1'b1;
         cnt_in = '0;
         neg_in = dividend[SUM_W-1];
         ovf_in = hi_ext >= CMP_W'(divisor);
         rem_in = hi_ext[DIV_W-1:0];
         quo_in = mag[QUO_W-1:0];
      end else if (run_ff) begin
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign neg  = neg_ff;
   assign ovf  = ovf_ff;

endmodule
